>>> rtl/sbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbq_pkg
// types, widths and arithmetic helpers shared by the stereo biquad filter
// ---------------------------------------------------------------------------
package sbq_pkg;

    localparam int WORD_BITS      = 32;
    localparam int SAMPLE_BITS    = 32;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int PROD_W         = COEF_BITS + SAMPLE_BITS;
    // five products plus the rounding term
    localparam int ACC_W          = PROD_W + 3;
    localparam int SHR_W          = ACC_W - COEF_FRAC_BITS;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic signed [ACC_W-1:0] ROUND_K =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [SHR_W-1:0] SAT_MAX =
        {{(SHR_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SHR_W-1:0] SAT_MIN =
        {{(SHR_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] left_sample;
        logic signed [WORD_BITS-1:0] right_sample;
        logic                        block_end;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] left_result;
        logic signed [WORD_BITS-1:0] right_result;
        logic                        block_end_out;
    } t_out_word;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

    // stage enables and the sum-stage busy flag from the pipeline control to every lane
    typedef struct packed {
        logic p_en;
        logic s_en;
        logic f_en;
        logic s_busy;
    } t_lane_ctl;

    // drop the fraction bits (rounding term added by the caller), then clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] f_saturate(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0]       shr;
        logic signed [SHR_W-1:0]       val;
        logic signed [SAMPLE_BITS-1:0] res;
        shr = acc >>> COEF_FRAC_BITS;
        val = signed'(shr[SHR_W-1:0]);
        if (val > SAT_MAX) begin
            res = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (val < SAT_MIN) begin
            res = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            res = val[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/sbq_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbq_lane
// one channel of the direct form I biquad: history, products, sum, saturate
// ---------------------------------------------------------------------------
module sbq_lane (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sbq_pkg::t_coefs                        i_coef,
    input  sbq_pkg::t_lane_ctl                     i_ctl,
    input  logic [sbq_pkg::WORD_BITS-1:0]          i_sample,
    output logic signed [sbq_pkg::WORD_BITS-1:0]   o_result
);
    import sbq_pkg::*;

    logic signed [SAMPLE_BITS-1:0] w_x;
    logic signed [SAMPLE_BITS-1:0] w_y2_sel;
    logic signed [PROD_W-1:0]      w_p0;
    logic signed [PROD_W-1:0]      w_p1;
    logic signed [PROD_W-1:0]      w_p2;
    logic signed [PROD_W-1:0]      w_a2p;
    logic signed [PROD_W-1:0]      w_a1p;
    logic signed [ACC_W-1:0]       w_ffsum;
    logic signed [ACC_W-1:0]       w_acc;
    logic signed [SAMPLE_BITS-1:0] n_y;

    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [SAMPLE_BITS-1:0] r_x2;
    logic signed [SAMPLE_BITS-1:0] r_y1;
    logic signed [SAMPLE_BITS-1:0] r_y2;
    logic signed [PROD_W-1:0]      r_p0;
    logic signed [PROD_W-1:0]      r_p1;
    logic signed [PROD_W-1:0]      r_p2;
    logic signed [ACC_W-1:0]       r_ffsum;
    logic signed [PROD_W-1:0]      r_a2p;

    assign w_x = signed'(i_sample[SAMPLE_BITS-1:0]);

    // feedforward products
    assign w_p0 = i_coef.b0 * w_x;
    assign w_p1 = i_coef.b1 * r_x1;
    assign w_p2 = i_coef.b2 * r_x2;

    assign w_ffsum = ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2) + ROUND_K;

    // while the word ahead is still in the sum stage, y two back sits in y1
    assign w_y2_sel = i_ctl.s_busy ? r_y1 : r_y2;
    assign w_a2p    = i_coef.a2 * w_y2_sel;

    // only the a1 term closes the loop combinationally through y1
    assign w_a1p = i_coef.a1 * r_y1;
    assign w_acc = r_ffsum - ACC_W'(r_a2p) - ACC_W'(w_a1p);
    assign n_y   = f_saturate(w_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else begin
            if (i_ctl.p_en) begin
                r_x1 <= w_x;
                r_x2 <= r_x1;
            end
            if (i_ctl.f_en) begin
                r_y1 <= n_y;
                r_y2 <= r_y1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.p_en) begin
            r_p0 <= w_p0;
            r_p1 <= w_p1;
            r_p2 <= w_p2;
        end
        if (i_ctl.s_en) begin
            r_ffsum <= w_ffsum;
            r_a2p   <= w_a2p;
        end
    end

    // y1 doubles as the output register of the lane
    assign o_result = WORD_BITS'(r_y1);

endmodule
`default_nettype wire

>>> rtl/sbq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbq_ctrl
// valid tracking and stage enables for the three stage filter pipeline
// ---------------------------------------------------------------------------
module sbq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sbq_pkg::t_lane_ctl o_ctl
);
    import sbq_pkg::*;

    logic r_p_valid;
    logic r_s_valid;
    logic r_o_valid;
    logic w_p_en;
    logic w_s_en;
    logic w_f_en;

    assign w_f_en     = r_s_valid && (!r_o_valid || !i_out_stall);
    assign w_s_en     = r_p_valid && (!r_s_valid || w_f_en);
    assign o_in_stall = r_p_valid && !w_s_en;
    assign w_p_en     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_p_valid <= w_p_en || (r_p_valid && !w_s_en);
            r_s_valid <= w_s_en || (r_s_valid && !w_f_en);
            r_o_valid <= w_f_en || (r_o_valid && i_out_stall);
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_ctl.p_en   = w_p_en;
    assign o_ctl.s_en   = w_s_en;
    assign o_ctl.f_en   = w_f_en;
    assign o_ctl.s_busy = r_s_valid;

endmodule
`default_nettype wire

>>> rtl/stereo_biquad_iir_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stereo_biquad_iir_filter
// direct form I second-order IIR over a stereo Q1.31 pair, shared Q4.28 coefs
// ---------------------------------------------------------------------------
// input channel: i_in_valid / o_in_stall carry one stereo word and a buffer
// end marker; a word is taken on an edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall carry the filtered pair and the
// marker copied through unchanged.
// coefficient port: i_cfg_valid / o_cfg_ready with index 0..4 for b0, b1, b2,
// a1, a2; other indexes are dropped. write only while the filter is idle.
// a taken word passes the product, sum and output registers before it shows.
// throughput: one word per cycle while the output is not stalled; the a1
// product, the final add and the saturation close each lane's feedback loop.
// reset (synchronous, active low) empties the pipeline, clears both
// channels' history and loads b0 = 1.0 with all other coefficients zero.
// a stalled output holds its word; the two stages behind it fill and the
// input stalls only once all three stages hold a word.
// ---------------------------------------------------------------------------
module stereo_biquad_iir_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sbq_pkg::t_in_word                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sbq_pkg::t_out_word                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sbq_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sbq_pkg::WORD_BITS-1:0]       i_cfg_data
);
    import sbq_pkg::*;

    t_coefs    r_coef;
    t_lane_ctl w_ctl;
    logic      r_p_end;
    logic      r_s_end;
    logic      r_o_end;
    logic signed [WORD_BITS-1:0] w_left;
    logic signed [WORD_BITS-1:0] w_right;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.b0 <= COEF_ONE;
            r_coef.b1 <= '0;
            r_coef.b2 <= '0;
            r_coef.a1 <= '0;
            r_coef.a2 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_B0:  r_coef.b0 <= signed'(i_cfg_data);
                REG_B1:  r_coef.b1 <= signed'(i_cfg_data);
                REG_B2:  r_coef.b2 <= signed'(i_cfg_data);
                REG_A1:  r_coef.a1 <= signed'(i_cfg_data);
                REG_A2:  r_coef.a2 <= signed'(i_cfg_data);
                default: ;
            endcase
        end
    end

    sbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (w_ctl)
    );

    sbq_lane u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (r_coef),
        .i_ctl    (w_ctl),
        .i_sample (i_in_data.left_sample),
        .o_result (w_left)
    );

    sbq_lane u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (r_coef),
        .i_ctl    (w_ctl),
        .i_sample (i_in_data.right_sample),
        .o_result (w_right)
    );

    // buffer end marker rides alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_ctl.p_en) begin
            r_p_end <= i_in_data.block_end;
        end
        if (w_ctl.s_en) begin
            r_s_end <= r_p_end;
        end
        if (w_ctl.f_en) begin
            r_o_end <= r_s_end;
        end
    end

    // merge both lanes into the output word
    assign o_out_data.left_result   = w_left;
    assign o_out_data.right_result  = w_right;
    assign o_out_data.block_end_out = r_o_end;

endmodule
`default_nettype wire

>>> rtl/sbq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sbq_checker
// port-level checks on the stereo biquad filter, bound to the top level
// ---------------------------------------------------------------------------
module sbq_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  sbq_pkg::t_out_word                  o_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready
);
    import sbq_pkg::*;

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // the pipeline is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    // the input only stalls when the output is full and itself stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free room downstream");

    // coefficient writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("coefficient write not taken");

endmodule

bind stereo_biquad_iir_filter sbq_checker u_sbq_checker (.*);
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the stereo biquad filter: a bit-exact lane model
// predicts each filtered pair, directed words cover pass-through, spare
// coefficient indexes, saturation and rounding, then random words run
// under several coefficient sets and flow-control patterns
// ---------------------------------------------------------------------------
module tb_top;
    import sbq_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int CHUNK_WORDS = 100;
    localparam int ACC_BITS    = 80;
    localparam logic signed [ACC_BITS-1:0] LANE_MAX =
        (80'sd1 <<< (SAMPLE_BITS - 1)) - 80'sd1;
    localparam logic signed [ACC_BITS-1:0] LANE_MIN = -(80'sd1 <<< (SAMPLE_BITS - 1));
    localparam logic signed [ACC_BITS-1:0] HALF_LSB = 80'sd1 <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef enum int {
        COEF_WILD,
        COEF_STABLE,
        COEF_EDGES
    } t_coef_style;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    t_in_word               i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_word              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [WORD_BITS-1:0]   i_cfg_data  = '0;

    // predictor state: live coefficients and per-lane history (0 left, 1 right)
    logic signed [COEF_BITS-1:0] coef_live [5] = '{COEF_ONE, '0, '0, '0, '0};
    logic signed [WORD_BITS-1:0] lane_x1 [2] = '{'0, '0};
    logic signed [WORD_BITS-1:0] lane_x2 [2] = '{'0, '0};
    logic signed [WORD_BITS-1:0] lane_y1 [2] = '{'0, '0};
    logic signed [WORD_BITS-1:0] lane_y2 [2] = '{'0, '0};

    t_out_word pending_pairs [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        gap_pct        = 0;
    int        stall_pct      = 0;

    stereo_biquad_iir_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // one direct form I step on one lane, history updated with the clamped value
    function automatic logic signed [WORD_BITS-1:0] filter_lane(
        input int                          ch,
        input logic signed [WORD_BITS-1:0] x
    );
        logic signed [ACC_BITS-1:0]  acc;
        logic signed [WORD_BITS-1:0] y;
        acc = coef_live[REG_B0] * x;
        acc = acc + coef_live[REG_B1] * lane_x1[ch];
        acc = acc + coef_live[REG_B2] * lane_x2[ch];
        acc = acc - coef_live[REG_A1] * lane_y1[ch];
        acc = acc - coef_live[REG_A2] * lane_y2[ch];
        acc = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
        if (acc > LANE_MAX) begin
            acc = LANE_MAX;
        end else if (acc < LANE_MIN) begin
            acc = LANE_MIN;
        end
        y = acc[WORD_BITS-1:0];
        lane_x2[ch] = lane_x1[ch];
        lane_x1[ch] = x;
        lane_y2[ch] = lane_y1[ch];
        lane_y1[ch] = y;
        return y;
    endfunction

    always @(posedge i_clk) begin : pair_monitor
        t_out_word want;
        t_out_word got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index <= REG_A2) begin
                coef_live[i_cfg_index] = i_cfg_data;
            end
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pending_pairs.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected output word %h", $time, got);
                end else begin
                    want = pending_pairs.pop_front();
                    if (got.left_result !== want.left_result) begin
                        mismatch_count++;
                        $display("%0t: left_result expected %h actual %h",
                                 $time, want.left_result, got.left_result);
                    end
                    if (got.right_result !== want.right_result) begin
                        mismatch_count++;
                        $display("%0t: right_result expected %h actual %h",
                                 $time, want.right_result, got.right_result);
                    end
                    if (got.block_end_out !== want.block_end_out) begin
                        mismatch_count++;
                        $display("%0t: block_end_out expected %b actual %b",
                                 $time, want.block_end_out, got.block_end_out);
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want.left_result   = filter_lane(0, i_in_data.left_sample);
                want.right_result  = filter_lane(1, i_in_data.right_sample);
                want.block_end_out = i_in_data.block_end;
                pending_pairs.push_back(want);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress, %0d words outstanding", $time,
                         pending_pairs.size());
                $display("[stereo_biquad_iir_filter] ERROR");
                $finish;
            end
        end
    end

    task automatic send_pair(
        input logic signed [WORD_BITS-1:0] left,
        input logic signed [WORD_BITS-1:0] right,
        input logic                        last
    );
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{left_sample: left, right_sample: right, block_end: last};
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // drop valid and let every outstanding word drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_BITS-1:0] idx,
        input logic [WORD_BITS-1:0]    value
    );
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_coefs(
        input logic signed [COEF_BITS-1:0] b0,
        input logic signed [COEF_BITS-1:0] b1,
        input logic signed [COEF_BITS-1:0] b2,
        input logic signed [COEF_BITS-1:0] a1,
        input logic signed [COEF_BITS-1:0] a2,
        input bit                          poke_spare
    );
        logic signed [COEF_BITS-1:0] vals [5];
        t_reg_idx                    ri;
        vals = '{b0, b1, b2, a1, a2};
        wait_idle();
        ri = REG_B0;
        repeat (5) begin
            write_reg(ri, vals[ri]);
            ri = ri.next();
        end
        // indexes past a2 must leave every coefficient alone
        if (poke_spare) begin
            for (int s = int'(REG_A2) + 1; s < (1 << CFG_IDX_BITS); s++) begin
                write_reg(s[CFG_IDX_BITS-1:0], $urandom);
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [COEF_BITS-1:0] coef_edge();
        case ($urandom_range(6))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return COEF_ONE;
            3:       return -COEF_ONE;
            4:       return 1;
            5:       return -1;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [COEF_BITS-1:0] pick_coef(
        input t_coef_style style,
        input int          shift
    );
        case (style)
            COEF_WILD:   return $urandom;
            COEF_STABLE: return $signed($urandom) >>> shift;
            default:     return coef_edge();
        endcase
    endfunction

    function automatic logic signed [WORD_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(9);
        if (r < 6) begin
            return $urandom;
        end else if (r < 9) begin
            return $signed($urandom) >>> $urandom_range(24, 8);
        end
        return ($urandom_range(1) != 0) ? WORD_MAX : WORD_MIN;
    endfunction

    task automatic test_passthrough();
        send_pair('0, '0, 1'b0);
        send_pair(1, -1, 1'b1);
        send_pair(WORD_MAX, WORD_MIN, 1'b0);
        send_pair(WORD_MIN, WORD_MAX, 1'b1);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        send_pair(-1, 1, 1'b0);
    endtask

    task automatic test_spare_index();
        load_coefs(COEF_ONE, '0, '0, '0, '0, 1'b1);
        send_pair(32'h1234_5678, -32'sd98765, 1'b1);
        send_pair(WORD_MIN, WORD_MAX, 1'b0);
    endtask

    task automatic test_saturation();
        load_coefs(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0);
        repeat (3) send_pair(WORD_MAX, WORD_MIN, 1'b0);
        repeat (3) send_pair(WORD_MIN, WORD_MAX, 1'b1);
    endtask

    // smallest b0 puts the rounding point right on a sample lsb
    task automatic test_rounding();
        load_coefs(1, '0, '0, '0, '0, 1'b0);
        send_pair(32'sd1 <<< 27, -(32'sd1 <<< 27), 1'b0);
        send_pair((32'sd1 <<< 27) - 1, -(32'sd1 <<< 27) - 1, 1'b1);
        load_coefs(-1, 1, -1, 1, -1, 1'b0);
        send_pair(32'sd3 <<< 27, -(32'sd3 <<< 27), 1'b0);
        send_pair(32'sd1 <<< 27, WORD_MAX, 1'b1);
    endtask

    task automatic test_random(input int sender_idle, input int receiver_idle,
                               input int chunks);
        t_coef_style style;
        gap_pct   = sender_idle;
        stall_pct = receiver_idle;
        repeat (chunks) begin
            style = t_coef_style'($urandom_range(2));
            load_coefs(pick_coef(style, 4), pick_coef(style, 4), pick_coef(style, 4),
                       pick_coef(style, 4), pick_coef(style, 5),
                       $urandom_range(3) == 0);
            repeat (CHUNK_WORDS) begin
                send_pair(pick_sample(), pick_sample(), $urandom_range(7) == 0);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough();
        test_spare_index();
        test_saturation();
        test_rounding();
        test_random(7, 64, 6);
        test_random(64, 7, 6);
        test_random(0, 0, 5);
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pairs.size() == 0) begin
            $display("[stereo_biquad_iir_filter] OK");
        end else begin
            $display("[stereo_biquad_iir_filter] ERROR");
        end
        $finish;
    end

endmodule
